// File: design/picl_pkg.sv
// Shared widths and defaults for the lattice polygon point counter.
// No dependencies; compiled before the interfaces and the core.
package picl_pkg;

  localparam int unsigned COORD_W_DEF = 16;
  localparam int unsigned CROSS_W     = 48;
  localparam int unsigned BOUND_W     = 40;
  localparam int unsigned INTER_W     = 33;
  localparam int unsigned AREA_W      = 34;
  localparam int unsigned BCNT_W      = 34;

endpackage

// File: design/picl_if.sv
// Valid/ready channel interfaces for vertex input and count results.
// Depends on picl_pkg for default and result widths.
interface picl_vtx_if #(
  parameter int unsigned COORD_WIDTH = picl_pkg::COORD_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface picl_res_if;
  import picl_pkg::*;

  logic               valid;
  logic               ready;
  logic [INTER_W-1:0] interior_count;
  logic [AREA_W-1:0]  double_area;
  logic [BCNT_W-1:0]  boundary_count;
  logic               degenerate;

  modport source (output valid, interior_count, double_area, boundary_count, degenerate,
                  input ready);
  modport sink   (input valid, interior_count, double_area, boundary_count, degenerate,
                  output ready);
endinterface

// File: design/polygon_interior_lattice_count_core.sv
// Pick's theorem lattice point counter: one shared multiplier, one binary gcd step unit.
// Each edge runs the multiply/accumulate states S_MULA, S_MULB, S_MULC, then the gcd loop.
// A first vertex sets the start; a later one runs the edge from the previous; the last also runs
// the closing edge, then S_ABS, S_DIFF, S_EMIT form the result. Vertices are taken only in S_IDLE.
// Reset (async, active low) clears the sequencer, the accumulators and the output valid.
// Depends on picl_pkg and the channel interfaces in picl_if.sv.
module polygon_interior_lattice_count_core #(
  parameter int unsigned COORD_WIDTH = picl_pkg::COORD_W_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  picl_vtx_if.sink  vtx_i,
  picl_res_if.source res_o
);
  import picl_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned MW = CW + 1;
  localparam int unsigned KW = $clog2(MW + 1);
  localparam int unsigned DW = CROSS_W + 1;

  localparam logic [DW-1:0]      INTER_MAX = DW'(1) << (INTER_W - 1);
  localparam logic [CROSS_W-1:0] AREA_MAX  = CROSS_W'(1) << (AREA_W - 1);
  localparam logic [BOUND_W-1:0] BCNT_MAX  = BOUND_W'(1) << (BCNT_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MULA, S_MULB, S_MULC, S_GCD, S_ABS, S_DIFF, S_EMIT
  } state_e;

  state_e               state_q;
  logic                 have_first_q, last_q, closing_q;
  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] px_q, py_q, qx_q, qy_q;
  logic [CROSS_W-1:0]   prod_q, cross_q, area_q;
  logic [BOUND_W-1:0]   bound_q;
  logic [MW-1:0]        ga_q, gb_q;
  logic [KW-1:0]        k_q;
  logic signed [DW-1:0] diff_q;

  logic               out_valid_q, degen_q;
  logic [INTER_W-1:0] inter_q;
  logic [AREA_W-1:0]  area_out_q;
  logic [BCNT_W-1:0]  bcnt_q;

  // shared multiplier
  logic signed [CW-1:0]   mul_a, mul_b;
  logic signed [2*CW-1:0] mul_p;
  logic signed [63:0]     mul_ext;
  logic signed [MW-1:0]   dx, dy;
  logic [MW-1:0]          mag_x, mag_y;
  logic                   gcd_done;
  logic [MW-1:0]          gcd_val;
  logic signed [DW-1:0]   half, pick;
  logic [1:0]             pick_inc;
  logic [INTER_W-1:0]     inter_d;
  logic                   in_fire, emit_fire;

  always_comb begin
    mul_a   = (state_q == S_MULA) ? px_q : py_q;
    mul_b   = (state_q == S_MULA) ? qy_q : qx_q;
    mul_p   = mul_a * mul_b;
    mul_ext = 64'(mul_p);

    dx    = MW'(qx_q) - MW'(px_q);
    dy    = MW'(qy_q) - MW'(py_q);
    mag_x = dx[MW-1] ? MW'(-dx) : MW'(dx);
    mag_y = dy[MW-1] ? MW'(-dy) : MW'(dy);

    // one operand is zero at the end, so the OR is the other one
    gcd_done = (ga_q == '0) || (gb_q == '0);
    gcd_val  = (ga_q | gb_q) << k_q;

    // halve truncating toward zero, then add one
    half     = diff_q >>> 1;
    pick_inc = (diff_q[DW-1] && diff_q[0]) ? 2'd2 : 2'd1;
    pick     = half + DW'(pick_inc);
    if (pick[DW-1]) begin
      inter_d = '0;
    end else if (pick > INTER_MAX) begin
      inter_d = INTER_W'(INTER_MAX);
    end else begin
      inter_d = pick[INTER_W-1:0];
    end
  end

  assign vtx_i.ready = (state_q == S_IDLE);
  assign in_fire     = vtx_i.valid && vtx_i.ready;
  assign emit_fire   = (state_q == S_EMIT) && (!out_valid_q || res_o.ready);

  assign res_o.valid          = out_valid_q;
  assign res_o.interior_count = inter_q;
  assign res_o.double_area    = area_out_q;
  assign res_o.boundary_count = bcnt_q;
  assign res_o.degenerate     = degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      have_first_q <= 1'b0;
      last_q       <= 1'b0;
      closing_q    <= 1'b0;
      cross_q      <= '0;
      bound_q      <= '0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (res_o.valid && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            last_q   <= vtx_i.last_vertex;
            prev_x_q <= vtx_i.vertex_x;
            prev_y_q <= vtx_i.vertex_y;
            qx_q     <= vtx_i.vertex_x;
            qy_q     <= vtx_i.vertex_y;
            if (!have_first_q) begin
              first_x_q    <= vtx_i.vertex_x;
              first_y_q    <= vtx_i.vertex_y;
              have_first_q <= 1'b1;
              cross_q      <= '0;
              bound_q      <= '0;
              // lone vertex closing on itself: empty edge
              px_q         <= vtx_i.vertex_x;
              py_q         <= vtx_i.vertex_y;
              closing_q    <= 1'b1;
              if (vtx_i.last_vertex) begin
                state_q <= S_MULA;
              end
            end else begin
              px_q      <= prev_x_q;
              py_q      <= prev_y_q;
              closing_q <= 1'b0;
              state_q   <= S_MULA;
            end
          end
        end
        S_MULA: begin
          prod_q  <= mul_ext[CROSS_W-1:0];
          ga_q    <= mag_x;
          gb_q    <= mag_y;
          k_q     <= '0;
          state_q <= S_MULB;
        end
        S_MULB: begin
          cross_q <= cross_q + prod_q;
          prod_q  <= mul_ext[CROSS_W-1:0];
          state_q <= S_MULC;
        end
        S_MULC: begin
          cross_q <= cross_q - prod_q;
          state_q <= S_GCD;
        end
        S_GCD: begin
          if (gcd_done) begin
            bound_q <= bound_q + BOUND_W'(gcd_val);
            if (last_q && !closing_q) begin
              // closing edge: current vertex back to the first
              px_q      <= prev_x_q;
              py_q      <= prev_y_q;
              qx_q      <= first_x_q;
              qy_q      <= first_y_q;
              closing_q <= 1'b1;
              state_q   <= S_MULA;
            end else if (last_q) begin
              state_q <= S_ABS;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (!ga_q[0] && !gb_q[0]) begin
            ga_q <= ga_q >> 1;
            gb_q <= gb_q >> 1;
            k_q  <= k_q + KW'(1);
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q >= gb_q) begin
            ga_q <= (ga_q - gb_q) >> 1;
          end else begin
            gb_q <= (gb_q - ga_q) >> 1;
          end
        end
        S_ABS: begin
          area_q  <= cross_q[CROSS_W-1] ? (~cross_q + CROSS_W'(1)) : cross_q;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          diff_q  <= $signed({1'b0, area_q}) - $signed({{(DW-BOUND_W){1'b0}}, bound_q});
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit_fire) begin
            inter_q      <= inter_d;
            degen_q      <= pick[DW-1];
            area_out_q   <= (area_q > AREA_MAX) ? AREA_W'(AREA_MAX) : AREA_W'(area_q);
            bcnt_q       <= (bound_q > BCNT_MAX) ? BCNT_W'(BCNT_MAX) : BCNT_W'(bound_q);
            have_first_q <= 1'b0;
            cross_q      <= '0;
            bound_q      <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (cross_q == '0) && (bound_q == '0) && !have_first_q && out_valid_q)
    else $error("accumulators not cleared after result");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.degenerate) |-> (res_o.interior_count == '0))
    else $error("degenerate result with nonzero interior count");

  a_gcd_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GCD) |-> (k_q <= KW'(MW)))
    else $error("gcd common shift out of range");

  a_close_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_GCD) && gcd_done && last_q && closing_q) |=> (state_q == S_ABS))
    else $error("closing edge did not lead to result");
`endif

endmodule
